// ===== hw/rtl/hss_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the 3d heat stencil sweep
package hss_pkg;

  localparam int MAX_EDGE_DEF    = 32;
  localparam int MIN_EDGE        = 3;
  localparam int VOXEL_W         = 32;
  localparam int GRID_SIZE_W     = 6;
  localparam int STEP_OFFSET_W   = 19;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = STEP_OFFSET_W;
  localparam int GRID_SIZE_RST   = 32;
  localparam int STEP_OFFSET_RST = 65536;
  localparam int OFIFO_DEPTH     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE   = 1'b0,
    REG_STEP_OFFSET = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [VOXEL_W-1:0] voxel_in;
    logic                      flush;
  } in_word_t;

  typedef struct packed {
    logic signed [VOXEL_W-1:0] voxel_out;
    logic                      grid_last;
  } out_word_t;

endpackage

// ===== hw/rtl/heat_stencil_3d_sweep.sv =====
`timescale 1ns / 1ps
// seven-point 3d heat stencil, one sweep over a streamed n-cube
// a result word passes stages 1 to 4 and the output queue on its way to out_valid
// throughput: one word per cycle while the output queue has room; a flush word that lands on an interior voxel
//   first holds in_ready low, as the forward plane tap then needs its own read on the window memory port
// reset: positions, counts and queue cleared, grid size 32 (capped at MAX_EDGE), offset 1.0;
//   the window memory is not cleared and holds garbage until written
module heat_stencil_3d_sweep
  import hss_pkg::*;
#(
  parameter int MAX_EDGE = MAX_EDGE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WIN_DEPTH = 2 * MAX_EDGE * MAX_EDGE + 1;
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int NW        = $clog2(MAX_EDGE + 1);
  localparam int PW        = $clog2(MAX_EDGE * MAX_EDGE + 2);
  localparam int N_RST     = (GRID_SIZE_RST > MAX_EDGE) ? MAX_EDGE : GRID_SIZE_RST;
  localparam int FW        = $clog2(OFIFO_DEPTH);
  localparam int CW        = $clog2(OFIFO_DEPTH + 1);
  localparam logic [AW:0] DEPTH_V = (AW + 1)'(WIN_DEPTH);
  localparam logic [VOXEL_W-1:0] SAT_MAX = {1'b0, {(VOXEL_W - 1){1'b1}}};
  localparam logic [VOXEL_W-1:0] SAT_MIN = {1'b1, {(VOXEL_W - 1){1'b0}}};

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, k};
    if (s >= DEPTH_V) s = s - DEPTH_V;
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a, input logic [AW-1:0] k);
    logic [AW:0] s;
    if (a >= k) s = {1'b0, a} - {1'b0, k};
    else        s = {1'b0, a} + DEPTH_V - {1'b0, k};
    return s[AW-1:0];
  endfunction

  // configuration
  logic [NW-1:0]            n_r, n_nxt, n_cl;
  logic [PW-1:0]            plane_r, plane_nxt;
  logic [STEP_OFFSET_W-1:0] offset_r, offset_nxt;
  logic [GRID_SIZE_W-1:0]   gs;

  // stream state
  logic [AW-1:0] ws_r, ws_nxt;     // next write slot
  logic [AW-1:0] cs_r, cs_nxt;     // slot of the next centre voxel
  logic [PW-1:0] pend_r, pend_nxt;
  logic [NW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic          pre_done_r, pre_done_nxt;
  logic [CW-1:0] cr_r, cr_nxt;

  logic acc, is_flush, emit, interior, last, pre_need, wr_en, pop;
  logic [AW-1:0] addr_p1, addr_pn, addr_mn, addr_mp, addr_pp, addr_a;

  // window memories, two identical copies for four read ports
  logic [VOXEL_W-1:0] win_a_mem [WIN_DEPTH];
  logic [VOXEL_W-1:0] win_b_mem [WIN_DEPTH];
  logic [VOXEL_W-1:0] rd_a_r, rd_b_r, rd_c_r, rd_d_r;

  // centre and west neighbor held in registers
  logic [VOXEL_W-1:0] hn_r, pc_r;

  // pipeline
  logic                 s1_v_r, s1_int_r, s1_last_r;
  logic [VOXEL_W-1:0]   s1_e_r;
  logic                 s2_v_r, s2_int_r, s2_last_r;
  logic [VOXEL_W-1:0]   s2_cen_r, s2_se_r;
  logic [VOXEL_W+1:0]   s2_sa_r;
  logic [VOXEL_W:0]     s2_sb_r, s2_sc_r;
  logic                 s3_v_r, s3_int_r, s3_last_r;
  logic [VOXEL_W-1:0]   s3_cen_r;
  logic [VOXEL_W+2:0]   s3_t1_r;
  logic [VOXEL_W+1:0]   s3_t2_r;
  logic                 s4_v_r, s4_int_r, s4_last_r;
  logic [VOXEL_W-1:0]   s4_cen_r;
  logic [VOXEL_W+2:0]   s4_t_r;
  logic [VOXEL_W-1:0]   q, res;
  logic [VOXEL_W:0]     r;
  out_word_t            fifo_in;

  // output queue
  out_word_t     ofifo_mem [OFIFO_DEPTH];
  logic [FW:0]   wp_r, rp_r, occ;

  assign acc      = in_valid && in_ready;
  assign is_flush = in_data.flush;
  assign wr_en    = acc && !is_flush;
  assign interior = (x_r != '0) && (x_r < n_r - NW'(1)) &&
                    (y_r != '0) && (y_r < n_r - NW'(1)) &&
                    (z_r != '0) && (z_r < n_r - NW'(1));
  assign last     = (x_r == n_r - NW'(1)) && (y_r == n_r - NW'(1)) && (z_r == n_r - NW'(1));
  assign emit     = is_flush ? (pend_r != '0) : (pend_r >= plane_r);
  // interior flush needs the forward plane tap from memory first
  assign pre_need = in_valid && is_flush && (pend_r != '0) && interior && !pre_done_r;
  assign in_ready = !pre_need && (cr_r < CW'(OFIFO_DEPTH));

  assign addr_p1 = ring_add(cs_r, AW'(1));
  assign addr_pn = ring_add(cs_r, AW'(n_r));
  assign addr_mn = ring_sub(cs_r, AW'(n_r));
  assign addr_mp = ring_sub(cs_r, AW'(plane_r));
  assign addr_pp = ring_add(cs_r, AW'(plane_r));
  assign addr_a  = pre_need ? addr_pp : addr_p1;

  always_comb begin
    gs = cfg_wdata[GRID_SIZE_W-1:0];
    if (gs < GRID_SIZE_W'(MIN_EDGE)) begin
      n_cl = NW'(MIN_EDGE);
    end else if ({1'b0, gs} > (GRID_SIZE_W + 1)'(MAX_EDGE)) begin
      n_cl = NW'(MAX_EDGE);
    end else begin
      n_cl = NW'(gs);
    end
  end

  always_comb begin
    n_nxt        = n_r;
    plane_nxt    = plane_r;
    offset_nxt   = offset_r;
    ws_nxt       = ws_r;
    cs_nxt       = cs_r;
    pend_nxt     = pend_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    pre_done_nxt = pre_done_r;
    if (pre_need) begin
      pre_done_nxt = 1'b1;
    end
    if (acc) begin
      pre_done_nxt = 1'b0;
      if (!is_flush) begin
        ws_nxt = ring_add(ws_r, AW'(1));
      end
      if (emit) begin
        cs_nxt = ring_add(cs_r, AW'(1));
        if (is_flush) begin
          pend_nxt = pend_r - PW'(1);
        end
        if (x_r == n_r - NW'(1)) begin
          x_nxt = '0;
          if (y_r == n_r - NW'(1)) begin
            y_nxt = '0;
            z_nxt = (z_r == n_r - NW'(1)) ? '0 : z_r + NW'(1);
          end else begin
            y_nxt = y_r + NW'(1);
          end
        end else begin
          x_nxt = x_r + NW'(1);
        end
      end else if (!is_flush) begin
        pend_nxt = pend_r + PW'(1);
      end
    end
    if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SIZE: begin
          n_nxt        = n_cl;
          plane_nxt    = PW'(n_cl) * PW'(n_cl);
          ws_nxt       = '0;
          cs_nxt       = '0;
          pend_nxt     = '0;
          x_nxt        = '0;
          y_nxt        = '0;
          z_nxt        = '0;
          pre_done_nxt = 1'b0;
        end
        REG_STEP_OFFSET: begin
          offset_nxt = cfg_wdata[STEP_OFFSET_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign pop    = out_valid && out_ready;
  assign cr_nxt = cr_r + CW'(acc && emit) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r        <= NW'(N_RST);
      plane_r    <= PW'(N_RST * N_RST);
      offset_r   <= STEP_OFFSET_W'(STEP_OFFSET_RST);
      ws_r       <= '0;
      cs_r       <= '0;
      pend_r     <= '0;
      x_r        <= '0;
      y_r        <= '0;
      z_r        <= '0;
      pre_done_r <= 1'b0;
      cr_r       <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      s4_v_r     <= 1'b0;
      wp_r       <= '0;
      rp_r       <= '0;
    end else begin
      n_r        <= n_nxt;
      plane_r    <= plane_nxt;
      offset_r   <= offset_nxt;
      ws_r       <= ws_nxt;
      cs_r       <= cs_nxt;
      pend_r     <= pend_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      z_r        <= z_nxt;
      pre_done_r <= pre_done_nxt;
      cr_r       <= cr_nxt;
      s1_v_r     <= acc && emit;
      s2_v_r     <= s1_v_r;
      s3_v_r     <= s2_v_r;
      s4_v_r     <= s3_v_r;
      if (s4_v_r) begin
        wp_r <= wp_r + (FW + 1)'(1);
      end
      if (pop) begin
        rp_r <= rp_r + (FW + 1)'(1);
      end
    end
  end

  // east or forward plane, and north-forward taps
  always_ff @(posedge clk) begin
    if (wr_en) win_a_mem[ws_r] <= in_data.voxel_in;
    if (acc || pre_need) rd_a_r <= win_a_mem[addr_a];
    if (acc) rd_b_r <= win_a_mem[addr_pn];
  end

  // backward row and plane taps
  always_ff @(posedge clk) begin
    if (wr_en) win_b_mem[ws_r] <= in_data.voxel_in;
    if (acc) rd_c_r <= win_b_mem[addr_mn];
    if (acc) rd_d_r <= win_b_mem[addr_mp];
  end

  // stage 1: capture flags and the forward plane tap
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_int_r  <= interior;
      s1_last_r <= last;
      s1_e_r    <= is_flush ? rd_a_r : in_data.voxel_in;
    end
  end

  // next centre comes from this centre's east tap, or from the word written into
  // its slot when the window had drained
  always_ff @(posedge clk) begin
    if (s1_v_r) pc_r <= hn_r;
    if (wr_en && pend_r == '0) begin
      hn_r <= in_data.voxel_in;
    end else if (s1_v_r) begin
      hn_r <= rd_a_r;
    end
  end

  // stage 2: partial sums
  always_ff @(posedge clk) begin
    s2_int_r  <= s1_int_r;
    s2_last_r <= s1_last_r;
    s2_cen_r  <= hn_r;
    s2_se_r   <= s1_e_r;
    s2_sa_r   <= {hn_r[VOXEL_W-1], hn_r, 1'b0} + {{2{pc_r[VOXEL_W-1]}}, pc_r};
    s2_sb_r   <= {rd_a_r[VOXEL_W-1], rd_a_r} + {rd_b_r[VOXEL_W-1], rd_b_r};
    s2_sc_r   <= {rd_c_r[VOXEL_W-1], rd_c_r} + {rd_d_r[VOXEL_W-1], rd_d_r};
  end

  // stage 3
  always_ff @(posedge clk) begin
    s3_int_r  <= s2_int_r;
    s3_last_r <= s2_last_r;
    s3_cen_r  <= s2_cen_r;
    s3_t1_r   <= {s2_sa_r[VOXEL_W+1], s2_sa_r} + {{2{s2_sb_r[VOXEL_W]}}, s2_sb_r};
    s3_t2_r   <= {s2_sc_r[VOXEL_W], s2_sc_r} + {{2{s2_se_r[VOXEL_W-1]}}, s2_se_r};
  end

  // stage 4: full sum with rounding bias
  always_ff @(posedge clk) begin
    s4_int_r  <= s3_int_r;
    s4_last_r <= s3_last_r;
    s4_cen_r  <= s3_cen_r;
    s4_t_r    <= s3_t1_r + {s3_t2_r[VOXEL_W+1], s3_t2_r} + (VOXEL_W + 3)'(4);
  end

  // stage 5: divide by eight, add offset, saturate; boundary voxels pass the centre through
  always_comb begin
    q = s4_t_r[VOXEL_W+2:3];
    r = {q[VOXEL_W-1], q} + {{(VOXEL_W + 1 - STEP_OFFSET_W){1'b0}}, offset_r};
    if (r[VOXEL_W] != r[VOXEL_W-1]) begin
      res = r[VOXEL_W] ? SAT_MIN : SAT_MAX;
    end else begin
      res = r[VOXEL_W-1:0];
    end
    fifo_in.voxel_out = s4_int_r ? res : s4_cen_r;
    fifo_in.grid_last = s4_last_r;
  end

  always_ff @(posedge clk) begin
    if (s4_v_r) ofifo_mem[wp_r[FW-1:0]] <= fifo_in;
  end

  assign occ       = wp_r - rp_r;
  assign out_valid = (wp_r != rp_r);
  assign out_data  = ofifo_mem[rp_r[FW-1:0]];

  a_queue_credit: assert property (@(posedge clk) disable iff (!rst_n)
    ({{(CW > FW + 1 ? CW - FW - 1 : 0){1'b0}}, occ} <= cr_r))
    else $error("output queue holds more words than were granted");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r <= plane_r))
    else $error("pending count above one plane");

  a_fwd_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !is_flush && emit) |-> (addr_pp == ws_r))
    else $error("forward plane tap is not the slot being written");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (occ != (FW + 1)'(OFIFO_DEPTH)))
    else $error("write into a full output queue");

endmodule

// ===== bench/heat_stencil_3d_sweep_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the 3d heat stencil sweep: stencil predictor, random stream, stalls
module heat_stencil_3d_sweep_tb;
  import hss_pkg::*;

  localparam int RING_DEPTH = 2 * MAX_EDGE_DEF * MAX_EDGE_DEF + 1;
  localparam int CYCLE_LIMIT = 150000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 400;
  localparam longint VOXEL_MAX = 64'sd2147483647;
  localparam longint VOXEL_MIN = -VOXEL_MAX - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  heat_stencil_3d_sweep dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_word_t word_queue[$];
  out_word_t expected_voxels[$];
  bit steady = 1'b0;
  int errors = 0;
  int cycles = 0;
  int words_out = 0;
  int hold_left = 0;
  bit held = 1'b0;

  // mirror of the block: voxel ring, positions and registers
  logic [31:0] ring_words[RING_DEPTH];
  bit ring_filled[RING_DEPTH];
  logic [GRID_SIZE_W-1:0] grid_size_q = GRID_SIZE_RST;
  logic [STEP_OFFSET_W-1:0] step_offset_q = STEP_OFFSET_RST;
  int unsigned out_pos = 0;
  int unsigned wr_slot = 0;
  int unsigned n_waiting = 0;

  function automatic int unsigned edge_len();
    if (grid_size_q < MIN_EDGE) return MIN_EDGE;
    if (grid_size_q > MAX_EDGE_DEF) return MAX_EDGE_DEF;
    return grid_size_q;
  endfunction

  function automatic int unsigned ring_at(int unsigned base, int offs);
    return (base + RING_DEPTH + offs) % RING_DEPTH;
  endfunction

  // six face neighbours: +-1 column, +-1 row, +-1 plane
  function automatic int unsigned neighbour_slot(int unsigned c, int unsigned n, int k);
    int stride;
    stride = (k < 2) ? 1 : (k < 4) ? int'(n) : int'(n * n);
    return ring_at(c, (k % 2) ? -stride : stride);
  endfunction

  function automatic bit next_is_interior(int unsigned n);
    int unsigned x, y, z;
    x = out_pos % n;
    y = (out_pos / n) % n;
    z = out_pos / (n * n);
    return x >= 1 && x <= n - 2 && y >= 1 && y <= n - 2 && z >= 1 && z <= n - 2;
  endfunction

  // an early flush must not read a ring slot that was never written
  function automatic bit flush_is_safe();
    int unsigned n, c;
    if (n_waiting == 0) return 1'b1;
    n = edge_len();
    c = ring_at(wr_slot, -int'(n_waiting));
    if (!next_is_interior(n)) return 1'b1;
    for (int k = 0; k < 6; k++)
      if (!ring_filled[neighbour_slot(c, n, k)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic in_word_t voxel_word(logic [31:0] v);
    in_word_t w;
    w.voxel_in = v;
    w.flush = 1'b0;
    return w;
  endfunction

  function automatic in_word_t flush_word();
    in_word_t w;
    w.voxel_in = $urandom();
    w.flush = 1'b1;
    return w;
  endfunction

  function automatic logic [31:0] random_voxel();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      default: return $urandom();
    endcase
  endfunction

  // queue one word for the driver and work out the stencil result it releases
  task automatic issue(input in_word_t w);
    int unsigned n, c;
    longint acc;
    out_word_t r;
    n = edge_len();
    word_queue.push_back(w);
    if (!w.flush) begin
      ring_words[wr_slot] = w.voxel_in;
      ring_filled[wr_slot] = 1'b1;
      wr_slot = (wr_slot + 1) % RING_DEPTH;
      n_waiting++;
      if (n_waiting <= n * n) return;
    end else if (n_waiting == 0) begin
      return;
    end
    c = ring_at(wr_slot, -int'(n_waiting));
    acc = longint'(signed'(ring_words[c]));
    if (next_is_interior(n)) begin
      acc = 2 * acc;
      for (int k = 0; k < 6; k++)
        acc += longint'(signed'(ring_words[neighbour_slot(c, n, k)]));
      // divide by 8, round half up, then offset and clamp
      acc = ((acc + 4) >>> 3) + longint'(step_offset_q);
      if (acc > VOXEL_MAX) acc = VOXEL_MAX;
      if (acc < VOXEL_MIN) acc = VOXEL_MIN;
    end
    r.voxel_out = acc[31:0];
    r.grid_last = (out_pos == n * n * n - 1);
    out_pos = (out_pos + 1) % (n * n * n);
    n_waiting--;
    expected_voxels.push_back(r);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRID_SIZE) begin
      grid_size_q = value[GRID_SIZE_W-1:0];
      out_pos = 0;
      wr_slot = 0;
      n_waiting = 0;
    end else begin
      step_offset_q = value[STEP_OFFSET_W-1:0];
    end
  endtask

  task automatic settle();
    while (word_queue.size() != 0 || in_valid || expected_voxels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned grid, input int unsigned offset,
                           input int n_items, input int flush_pct, input bit drain);
    settle();
    write_reg(REG_GRID_SIZE, grid);
    write_reg(REG_STEP_OFFSET, offset);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < flush_pct && flush_is_safe()) issue(flush_word());
      else issue(voxel_word(random_voxel()));
    end
    if (drain) begin
      while (n_waiting != 0) begin
        if (flush_is_safe()) issue(flush_word());
        else issue(voxel_word(random_voxel()));
      end
    end
  endtask

  initial begin
    logic [31:0] v;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // smallest cube; the one interior voxel and its neighbours at full scale saturate
    write_reg(REG_GRID_SIZE, MIN_EDGE);
    write_reg(REG_STEP_OFFSET, STEP_OFFSET_RST);
    issue(flush_word());
    for (int i = 0; i < 27; i++) begin
      case (i)
        4, 10, 12, 13, 14, 16, 22: v = 32'h7FFF_FFFF;
        0, 26: v = 32'h8000_0000;
        default: v = $urandom();
      endcase
      issue(voxel_word(v));
    end
    while (n_waiting != 0) issue(flush_word());

    run_phase(0, 0, 54, 0, 1'b1);
    run_phase(4, 131072, 192, 5, 1'b1);
    settle();
    steady = 1'b1;
    run_phase(5, 262144, 250, 0, 1'b1);
    settle();
    steady = 1'b0;
    // noisy stream, lots of early flushes reading stale ring words
    run_phase(2, 524287, 120, 30, 1'b1);
    run_phase(6, 65536, 216, 3, 1'b1);
    // largest cube, far enough to reach interior voxels, then cut short by a restart
    run_phase(63, 262144, 2090, 0, 1'b0);
    run_phase(3, 131072, 81, 10, 1'b1);

    settle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (word_queue.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
        in_valid <= 1'b1;
        in_data <= word_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_voxels.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h", $time, out_data);
        errors++;
      end else begin
        want = expected_voxels.pop_front();
        if (out_data.voxel_out !== want.voxel_out) begin
          $display("%0t: voxel_out expected %h got %h", $time, want.voxel_out,
                   out_data.voxel_out);
          errors++;
        end
        if (out_data.grid_last !== want.grid_last) begin
          $display("%0t: grid_last expected %b got %b", $time, want.grid_last,
                   out_data.grid_last);
          errors++;
        end
      end
      words_out++;
    end
    // one long hold-off so the block backs up into its input
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (words_out >= HOLD_AT && !held) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || $urandom_range(99) >= 24;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
